/* design/pdtb_pkg.sv */
// Package for the pixel depth test and blend block.
// Holds the store geometry, register and function codes, the
// controller/datapath structs, the channel blend and depth test functions. No dependencies.
`timescale 1ns / 1ps
package pdtb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int XY_W       = 8;
    localparam int DIM_W      = 9;
    localparam int DEPTH_W    = 24;
    localparam int COLOR_W    = 24;

    localparam logic [DEPTH_W-1:0] DEPTH_ONE = 24'd4194304;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 24'h7FFFFF;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 24'h800000;

    localparam logic [2:0] CFG_DEPTH_FUNC   = 3'd0;
    localparam logic [2:0] CFG_DEPTH_WRITE  = 3'd1;
    localparam logic [2:0] CFG_BLEND_MODE   = 3'd2;
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd4;

    localparam logic [2:0] DF_ALWAYS    = 3'd0;
    localparam logic [2:0] DF_LESS      = 3'd1;
    localparam logic [2:0] DF_LEQUAL    = 3'd2;
    localparam logic [2:0] DF_GREATER   = 3'd3;
    localparam logic [2:0] DF_GEQUAL    = 3'd4;
    localparam logic [2:0] DF_EQUAL     = 3'd5;
    localparam logic [2:0] DF_NOTEQUAL  = 3'd6;
    localparam logic [2:0] DF_NEVER     = 3'd7;

    localparam logic [1:0] BM_REPLACE = 2'd0;
    localparam logic [1:0] BM_ADD     = 2'd1;
    localparam logic [1:0] BM_ALPHA   = 2'd2;
    localparam logic [1:0] BM_KEEP    = 2'd3;

    typedef struct packed {
        logic load;
        logic div_start;
        logic mem_read;
        logic eval;
        logic out_zero;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic out_of_frame;
        logic w_zero;
        logic div_done;
        logic clr_last;
    } t_sts;

    function automatic logic [7:0] blend_ch(input logic [1:0] mode, input logic [7:0] s,
                                            input logic [7:0] d, input logic [7:0] a);
        logic [8:0]  sum;
        logic [15:0] v;
        logic [16:0] t;
        logic [7:0]  res;
        sum = {1'b0, s} + {1'b0, d};
        v   = 16'(a * s) + 16'((8'd255 - a) * d) + 16'd127;
        t   = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
        case (mode)
            BM_REPLACE: res = s;
            BM_ADD:     res = sum[8] ? 8'hFF : sum[7:0];
            BM_ALPHA:   res = t[15:8];
            default:    res = d;
        endcase
        return res;
    endfunction

    function automatic logic depth_pass(input logic [2:0] func,
                                        input logic signed [DEPTH_W-1:0] nd,
                                        input logic signed [DEPTH_W-1:0] od);
        logic p;
        case (func)
            DF_ALWAYS:   p = 1'b1;
            DF_LESS:     p = nd < od;
            DF_LEQUAL:   p = nd <= od;
            DF_GREATER:  p = nd > od;
            DF_GEQUAL:   p = nd >= od;
            DF_EQUAL:    p = nd == od;
            DF_NOTEQUAL: p = nd != od;
            default:     p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

/* design/pdtb_div.sv */
// Iterative signed divider forming z * 2^22 / w, one quotient bit per cycle.
// Depends on pdtb_pkg for the depth width and saturation limits.
`timescale 1ns / 1ps
module pdtb_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [31:0]           i_z,
    input  logic signed [31:0]           i_w,
    output logic                         o_done,
    output logic [pdtb_pkg::DEPTH_W-1:0] o_depth
);
    localparam int QW = 54;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [5:0]    r_cnt, n_cnt;
    logic [QW-1:0] r_q, n_q;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_dvs, n_dvs;
    logic          r_neg, n_neg;
    logic [32:0]   sh;
    logic [33:0]   diff;
    logic [31:0]   abs_z, abs_w;

    assign abs_z = i_z[31] ? 32'(-i_z) : i_z;
    assign abs_w = i_w[31] ? 32'(-i_w) : i_w;
    assign sh    = {r_rem, r_q[QW-1]};
    assign diff  = {1'b0, sh} - {2'b00, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_q    = {abs_z, 22'd0};
            n_rem  = 32'd0;
            n_dvs  = abs_w;
            n_neg  = i_z[31] ^ i_w[31];
        end else if (r_busy) begin
            if (!diff[33]) begin
                n_rem = diff[31:0];
                n_q   = {r_q[QW-2:0], 1'b1};
            end else begin
                n_rem = sh[31:0];
                n_q   = {r_q[QW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(QW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    always_comb begin
        if (!r_neg) begin
            o_depth = (|r_q[QW-1:23]) ? pdtb_pkg::DEPTH_MAX : {1'b0, r_q[22:0]};
        end else if ((|r_q[QW-1:24]) || (r_q[23] && (|r_q[22:0]))) begin
            o_depth = pdtb_pkg::DEPTH_MIN;
        end else begin
            o_depth = 24'(-r_q[23:0]);
        end
    end

    assign o_done = r_done;
endmodule

/* design/pdtb_ctrl.sv */
// Controller state machine: store clearing, fragment sequencing and result timing.
// Depends on pdtb_pkg for the command and status structs.
`timescale 1ns / 1ps
module pdtb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pdtb_pkg::t_sts    i_sts,
    output pdtb_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EVAL  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.out_of_frame) begin
                    o_cmd.out_zero = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_sts.w_zero) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

/* design/pdtb_dp.sv */
// Datapath: configuration registers, depth and color stores, divider, test and blend.
// Depends on pdtb_pkg and pdtb_div.
`timescale 1ns / 1ps
module pdtb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdtb_pkg::t_cmd                i_cmd,
    output pdtb_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [pdtb_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic [pdtb_pkg::XY_W-1:0]     i_pixel_x,
    input  logic [pdtb_pkg::XY_W-1:0]     i_pixel_y,
    input  logic signed [31:0]            i_clip_z,
    input  logic signed [31:0]            i_clip_w,
    input  logic [7:0]                    i_src_red,
    input  logic [7:0]                    i_src_green,
    input  logic [7:0]                    i_src_blue,
    input  logic [7:0]                    i_src_alpha,
    output logic                          o_valid,
    output logic                          o_passed,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue,
    output logic signed [pdtb_pkg::DEPTH_W-1:0] o_out_depth
);
    localparam int ENTRIES = pdtb_pkg::MAX_WIDTH * pdtb_pkg::MAX_HEIGHT;
    localparam int AW      = pdtb_pkg::ADDR_W;
    localparam int DW      = pdtb_pkg::DEPTH_W;
    localparam int CW      = pdtb_pkg::COLOR_W;
    localparam int NW      = pdtb_pkg::DIM_W;

    logic [2:0]    r_depth_func;
    logic          r_depth_we;
    logic [1:0]    r_blend_mode;
    logic [NW-1:0] r_frame_w, r_frame_h;

    logic [DW-1:0] r_depth_mem [0:ENTRIES-1];
    logic [CW-1:0] r_color_mem [0:ENTRIES-1];

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] r_addr;
    logic          r_oob, r_wz;
    logic signed [31:0] r_z, r_w;
    logic [7:0]    r_sr, r_sg, r_sb, r_sa;
    logic [DW-1:0] r_nd;
    logic [DW-1:0] r_rd_depth;
    logic [CW-1:0] r_rd_color;

    logic [NW-1:0] eff_w, eff_h;
    logic          oob;
    logic [AW-1:0] addr;
    logic          div_done;
    logic [DW-1:0] div_depth;
    logic          pass;
    logic [CW-1:0] new_color;
    logic          wr_depth, wr_color;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_depth_data;
    logic [CW-1:0] wr_color_data;

    assign eff_w = (r_frame_w < NW'(pdtb_pkg::MAX_WIDTH)) ? r_frame_w : NW'(pdtb_pkg::MAX_WIDTH);
    assign eff_h = (r_frame_h < NW'(pdtb_pkg::MAX_HEIGHT)) ? r_frame_h : NW'(pdtb_pkg::MAX_HEIGHT);
    assign oob   = ({1'b0, i_pixel_x} >= eff_w) || ({1'b0, i_pixel_y} >= eff_h);
    assign addr  = AW'(i_pixel_y * eff_w + {1'b0, i_pixel_x});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_func <= pdtb_pkg::DF_LESS;
            r_depth_we   <= 1'b1;
            r_blend_mode <= pdtb_pkg::BM_REPLACE;
            r_frame_w    <= NW'(256);
            r_frame_h    <= NW'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pdtb_pkg::CFG_DEPTH_FUNC:   r_depth_func <= i_cfg_data[2:0];
                pdtb_pkg::CFG_DEPTH_WRITE:  r_depth_we   <= i_cfg_data[0];
                pdtb_pkg::CFG_BLEND_MODE:   r_blend_mode <= i_cfg_data[1:0];
                pdtb_pkg::CFG_FRAME_WIDTH:  r_frame_w    <= i_cfg_data;
                pdtb_pkg::CFG_FRAME_HEIGHT: r_frame_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= addr;
            r_oob  <= oob;
            r_wz   <= (i_clip_w == 32'sd0);
            r_z    <= i_clip_z;
            r_w    <= i_clip_w;
            r_sr   <= i_src_red;
            r_sg   <= i_src_green;
            r_sb   <= i_src_blue;
            r_sa   <= i_src_alpha;
        end
        if (i_cmd.mem_read) begin
            r_nd <= div_depth;
        end
    end

    pdtb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_z     (r_z),
        .i_w     (r_w),
        .o_done  (div_done),
        .o_depth (div_depth)
    );

    assign pass = !r_wz && pdtb_pkg::depth_pass(r_depth_func, r_nd, r_rd_depth);
    assign new_color = {pdtb_pkg::blend_ch(r_blend_mode, r_sb, r_rd_color[23:16], r_sa),
                        pdtb_pkg::blend_ch(r_blend_mode, r_sg, r_rd_color[15:8], r_sa),
                        pdtb_pkg::blend_ch(r_blend_mode, r_sr, r_rd_color[7:0], r_sa)};

    assign wr_depth      = i_cmd.clr_step || (i_cmd.eval && pass && r_depth_we);
    assign wr_color      = i_cmd.clr_step || (i_cmd.eval && pass);
    assign wr_addr       = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign wr_depth_data = i_cmd.clr_step ? pdtb_pkg::DEPTH_ONE : r_nd;
    assign wr_color_data = i_cmd.clr_step ? CW'(0) : new_color;

    always_ff @(posedge i_clk) begin
        if (wr_depth) r_depth_mem[wr_addr] <= wr_depth_data;
        if (wr_color) r_color_mem[wr_addr] <= wr_color_data;
        if (i_cmd.mem_read) begin
            r_rd_depth <= r_depth_mem[r_addr];
            r_rd_color <= r_color_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.eval || i_cmd.out_zero;
        end
        if (i_cmd.out_zero) begin
            o_passed    <= 1'b0;
            o_out_red   <= 8'd0;
            o_out_green <= 8'd0;
            o_out_blue  <= 8'd0;
            o_out_depth <= '0;
        end else if (i_cmd.eval) begin
            o_passed    <= pass;
            o_out_red   <= pass ? new_color[7:0]   : r_rd_color[7:0];
            o_out_green <= pass ? new_color[15:8]  : r_rd_color[15:8];
            o_out_blue  <= pass ? new_color[23:16] : r_rd_color[23:16];
            o_out_depth <= (pass && r_depth_we) ? r_nd : r_rd_depth;
        end
    end

    assign o_sts.out_of_frame = r_oob;
    assign o_sts.w_zero       = r_wz;
    assign o_sts.div_done     = div_done;
    assign o_sts.clr_last     = &r_clr_addr;
endmodule

/* design/pixel_depth_test_and_blend.sv */
// A fragment outside the frame gets a zero result straight after the frame check; for zero w the
// stores are read and the fragment fails, and otherwise the 54-step bit-serial divider runs first.
// One fragment is in work at a time; busy stays high until its result is shown.
// Reset: synchronous, active low; afterwards a clearing pass over the whole store sets every
// depth to 1.0 and every color to black, with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module pixel_depth_test_and_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [pdtb_pkg::DIM_W-1:0]    i_cfg_data,
    input  logic [7:0]                    i_pixel_x,
    input  logic [7:0]                    i_pixel_y,
    input  logic signed [31:0]            i_clip_z,
    input  logic signed [31:0]            i_clip_w,
    input  logic [7:0]                    i_src_red,
    input  logic [7:0]                    i_src_green,
    input  logic [7:0]                    i_src_blue,
    input  logic [7:0]                    i_src_alpha,
    output logic                          o_valid,
    output logic                          o_passed,
    output logic [7:0]                    o_out_red,
    output logic [7:0]                    o_out_green,
    output logic [7:0]                    o_out_blue,
    output logic signed [23:0]            o_out_depth
);
    pdtb_pkg::t_cmd cmd;
    pdtb_pkg::t_sts sts;

    pdtb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pdtb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_clip_z    (i_clip_z),
        .i_clip_w    (i_clip_w),
        .i_src_red   (i_src_red),
        .i_src_green (i_src_green),
        .i_src_blue  (i_src_blue),
        .i_src_alpha (i_src_alpha),
        .o_valid     (o_valid),
        .o_passed    (o_passed),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_depth (o_out_depth)
    );
endmodule

/* design/pdtb_checker.sv */
// Port-level checker for pixel_depth_test_and_blend, attached by bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module pdtb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy did not rise after a transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy while a result is shown");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("no clearing pass after reset");

    a_no_unsolicited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !o_valid && !start |=> !o_valid) else $error("result without a fragment");
endmodule

bind pixel_depth_test_and_blend pdtb_checker u_pdtb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid)
);
